>>> rtl/cdq_pkg.sv
// cdq_pkg: shared types and constants for the circular deque.
// Used by cdq_ctrl, cdq_datapath, circular_deque and the bench; depends on nothing.
package cdq_pkg;

    localparam int CDQ_DEPTH      = 1024;
    localparam int CDQ_DATA_WIDTH = 16;
    localparam int CDQ_CAP_RESET  = 1024;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture op and value
        logic exec;   // update indices, count and storage
        logic read;   // read front and rear entries
    } cmd_t;

endpackage

>>> rtl/cdq_ctrl.sv
// cdq_ctrl: sequencer of the circular deque, one word at a time.
// Depends on cdq_pkg for the state and command types.
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        cmd.read = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            ST_READ:
            begin
                busy     = 1'b1;
                cmd.read = 1'b1;
            end
            ST_DONE:
            begin
                // result shown while the next word may already be taken
                done     = 1'b1;
                cmd.load = start;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/cdq_datapath.sv
// cdq_datapath: storage, head/tail indices, occupancy and result registers.
// Depends on cdq_pkg for the command type and operation codes.
module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = CDQ_DEPTH,
    parameter int DATA_WIDTH = CDQ_DATA_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    input  logic [1:0]                     op,
    input  logic [DATA_WIDTH-1:0]          value,
    input  logic                           cfg_we,
    input  logic [$clog2(DEPTH+1)-1:0]     cfg_data,
    output logic                           ok,
    output logic                           is_empty,
    output logic                           is_full,
    output logic [DATA_WIDTH-1:0]          front_value,
    output logic [DATA_WIDTH-1:0]          rear_value
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_INIT = (DEPTH < CDQ_CAP_RESET) ? DEPTH : CDQ_CAP_RESET;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [CNT_W-1:0]      cap_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      tail_reg;
    logic [CNT_W-1:0]      occ_reg;
    logic [1:0]            op_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic                  ok_reg;
    logic                  empty_reg;
    logic                  full_reg;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] rear_reg;

    logic [IDX_W-1:0]      head_next;
    logic [IDX_W-1:0]      tail_next;
    logic [CNT_W-1:0]      occ_next;
    logic                  ok_next;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      cap_last;
    logic [IDX_W-1:0]      head_back;
    logic [IDX_W-1:0]      head_fwd;
    logic [IDX_W-1:0]      tail_back;
    logic [IDX_W-1:0]      tail_fwd;
    logic [CNT_W-1:0]      head_inc;
    logic [CNT_W-1:0]      tail_inc;
    logic [CNT_W-1:0]      cap_clamped;
    logic                  has_room;
    logic                  has_item;

    // zero acts as one, anything past the depth acts as the depth
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_clamped = CNT_W'(1);
        end
        else if (cfg_data > CNT_W'(DEPTH))
        begin
            cap_clamped = CNT_W'(DEPTH);
        end
        else
        begin
            cap_clamped = cfg_data;
        end
    end

    assign cap_last  = IDX_W'(cap_reg - CNT_W'(1));
    assign head_inc  = CNT_W'(head_reg) + CNT_W'(1);
    assign tail_inc  = CNT_W'(tail_reg) + CNT_W'(1);
    assign head_back = (head_reg == '0) ? cap_last : head_reg - IDX_W'(1);
    assign tail_back = (tail_reg == '0) ? cap_last : tail_reg - IDX_W'(1);
    assign head_fwd  = (head_inc >= cap_reg) ? '0 : head_inc[IDX_W-1:0];
    assign tail_fwd  = (tail_inc >= cap_reg) ? '0 : tail_inc[IDX_W-1:0];
    assign has_room  = (occ_reg < cap_reg);
    assign has_item  = (occ_reg != '0);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        ok_next   = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = tail_reg;
        case (op_reg)
            OP_PUSH_FRONT:
            begin
                if (has_room)
                begin
                    head_next = head_back;
                    occ_next  = occ_reg + CNT_W'(1);
                    ok_next   = 1'b1;
                    wr_en     = 1'b1;
                    wr_addr   = head_back;
                end
            end
            OP_PUSH_REAR:
            begin
                if (has_room)
                begin
                    tail_next = tail_fwd;
                    occ_next  = occ_reg + CNT_W'(1);
                    ok_next   = 1'b1;
                    wr_en     = 1'b1;
                    wr_addr   = tail_reg;
                end
            end
            OP_POP_FRONT:
            begin
                if (has_item)
                begin
                    head_next = head_fwd;
                    occ_next  = occ_reg - CNT_W'(1);
                    ok_next   = 1'b1;
                end
            end
            default:
            begin
                if (has_item)
                begin
                    tail_next = tail_back;
                    occ_next  = occ_reg - CNT_W'(1);
                    ok_next   = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CNT_W'(CAP_INIT);
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else if (cfg_we)
        begin
            // a capacity write also empties the queue
            cap_reg  <= cap_clamped;
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            ok_reg <= ok_next;
        end
        if (cmd.read)
        begin
            empty_reg <= (occ_reg == '0);
            full_reg  <= (occ_reg == cap_reg);
        end
    end

    // storage: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.read)
        begin
            front_reg <= mem[head_reg];
            rear_reg  <= mem[tail_back];
        end
    end

    assign ok          = ok_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;
    assign front_value = empty_reg ? '0 : front_reg;
    assign rear_value  = empty_reg ? '0 : rear_reg;

endmodule

>>> rtl/circular_deque.sv
// circular_deque: ring-buffer double-ended queue, top level.
// A word taken at a clock edge goes through the EXEC and READ states and shows its result
// (done) in DONE; start is not taken while busy, but is taken again in the cycle that shows
// the result. Storage update (EXEC) and the two-port read (READ) are separate states.
// Reset clears indices and occupancy and sets capacity to 1024 (at most DEPTH);
// storage is not cleared. The receiver cannot stall: each result shows for one cycle.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = CDQ_DEPTH,
    parameter int DATA_WIDTH = CDQ_DATA_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 op,
    input  logic [DATA_WIDTH-1:0]      value,
    input  logic                       cfg_we,
    input  logic [$clog2(DEPTH+1)-1:0] cfg_data,
    output logic                       done,
    output logic                       ok,
    output logic                       is_empty,
    output logic                       is_full,
    output logic [DATA_WIDTH-1:0]      front_value,
    output logic [DATA_WIDTH-1:0]      rear_value
);

    cmd_t cmd;

    cdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .ok          (ok),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .front_value (front_value),
        .rear_value  (rear_value)
    );

endmodule

>>> rtl/cdq_checker.sv
// cdq_checker: port-level timing checks for circular_deque, bound to the top level.
// Depends only on the top-level ports.
module cdq_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic is_empty,
    input logic is_full
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("word taken but block not busy next cycle");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result not shown three cycles after word taken");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of an operation");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_empty && is_full))
        else $error("queue reported both empty and full");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for circular_deque, with its own deque predictor.
// Depends on cdq_pkg and the circular_deque RTL.

module tb;
    import cdq_pkg::*;

    localparam int CAP_W     = $clog2(CDQ_DEPTH + 1);
    localparam int DW        = CDQ_DATA_WIDTH;
    localparam int IDX_W     = $clog2(CDQ_DEPTH);
    localparam int STALL_MAX = 1000;

    typedef struct {
        logic             is_cfg;
        logic [1:0]       op;
        logic [DW-1:0]    val;
        logic [CAP_W-1:0] cap;
        int               idle_pct;
    } deque_word_t;

    typedef struct {
        int            seq;
        logic          ok;
        logic          is_empty;
        logic          is_full;
        logic [DW-1:0] front;
        logic [DW-1:0] rear;
    } deque_outcome_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       op;
    logic [DW-1:0]    value;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;
    logic             done;
    logic             ok;
    logic             is_empty;
    logic             is_full;
    logic [DW-1:0]    front_value;
    logic [DW-1:0]    rear_value;

    circular_deque dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .ok          (ok),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .front_value (front_value),
        .rear_value  (rear_value)
    );

    // predictor state
    logic [DW-1:0]    dq_store [CDQ_DEPTH];
    logic [IDX_W-1:0] dq_head;
    logic [IDX_W-1:0] dq_tail;
    logic [CAP_W-1:0] dq_count;
    logic [CAP_W-1:0] dq_cap_reg;

    deque_word_t    pending_words [$];
    deque_outcome_t expected_q [$];

    int errors;
    int n_words;
    int n_refused;
    int n_full;
    int n_cfg;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [CAP_W-1:0] eff_capacity();
        if (dq_cap_reg == '0)
            return CAP_W'(1);
        if (dq_cap_reg > CAP_W'(CDQ_DEPTH))
            return CAP_W'(CDQ_DEPTH);
        return dq_cap_reg;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] last;
        last = cap - CAP_W'(1);
        return (i == '0) ? last[IDX_W-1:0] : i - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = {1'b0, i} + CAP_W'(1);
        return (n >= cap) ? '0 : n[IDX_W-1:0];
    endfunction

    // a capacity write also empties the deque; storage is kept
    task automatic deque_apply_capacity(input logic [CAP_W-1:0] cap);
        dq_cap_reg = cap;
        dq_head    = '0;
        dq_tail    = '0;
        dq_count   = '0;
        n_cfg++;
    endtask

    task automatic deque_predict(input logic [1:0] w_op, input logic [DW-1:0] w_val);
        logic [CAP_W-1:0] cap;
        deque_outcome_t   r;
        cap   = eff_capacity();
        r.seq = n_words;
        r.ok  = 1'b0;
        case (w_op)
            OP_PUSH_FRONT:
                if (dq_count < cap)
                begin
                    dq_head           = ring_prev(dq_head, cap);
                    dq_store[dq_head] = w_val;
                    dq_count++;
                    r.ok = 1'b1;
                end
            OP_PUSH_REAR:
                if (dq_count < cap)
                begin
                    dq_store[dq_tail] = w_val;
                    dq_tail           = ring_next(dq_tail, cap);
                    dq_count++;
                    r.ok = 1'b1;
                end
            OP_POP_FRONT:
                if (dq_count > 0)
                begin
                    dq_head = ring_next(dq_head, cap);
                    dq_count--;
                    r.ok = 1'b1;
                end
            default:
                if (dq_count > 0)
                begin
                    dq_tail = ring_prev(dq_tail, cap);
                    dq_count--;
                    r.ok = 1'b1;
                end
        endcase
        r.is_empty = (dq_count == 0);
        r.is_full  = (dq_count == cap);
        r.front    = '0;
        r.rear     = '0;
        if (!r.is_empty)
        begin
            r.front = dq_store[dq_head];
            r.rear  = dq_store[ring_prev(dq_tail, cap)];
        end
        if (!r.ok)
            n_refused++;
        if (r.is_full)
            n_full++;
        n_words++;
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(input int seq, input string what,
                                   input logic [DW-1:0] got, input logic [DW-1:0] want);
        $display("MISMATCH word %0d %s: got %h expected %h", seq, what, got, want);
        errors++;
    endtask

    // stimulus builders
    task automatic add_word(input logic [1:0] w_op, input logic [DW-1:0] w_val);
        deque_word_t w;
        w.is_cfg   = 1'b0;
        w.op       = w_op;
        w.val      = w_val;
        w.cap      = '0;
        w.idle_pct = 0;
        pending_words.push_back(w);
    endtask

    task automatic add_capacity(input int cap);
        deque_word_t w;
        w.is_cfg   = 1'b1;
        w.op       = OP_PUSH_FRONT;
        w.val      = '0;
        w.cap      = CAP_W'(cap);
        w.idle_pct = 0;
        pending_words.push_back(w);
    endtask

    task automatic add_random(input int cap, input int count, input int push_pct);
        logic [1:0]    w_op;
        logic [DW-1:0] w_val;
        add_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < push_pct)
                w_op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                w_op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
            case ($urandom_range(7))
                0:       w_val = '0;
                1:       w_val = '1;
                default: w_val = DW'($urandom);
            endcase
            add_word(w_op, w_val);
        end
    endtask

    // driver: one nonblocking write per signal per edge
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic             nxt_start;
        logic             nxt_we;
        logic [1:0]       nxt_op;
        logic [DW-1:0]    nxt_val;
        logic [CAP_W-1:0] nxt_cap;
        if (!rst_n)
        begin
            start    <= 1'b0;
            op       <= OP_PUSH_FRONT;
            value    <= '0;
            cfg_we   <= 1'b0;
            cfg_data <= '0;
        end
        else
        begin
            if (start && !busy)
                deque_predict(op, value);
            if (cfg_we)
                deque_apply_capacity(cfg_data);
            nxt_start = start && busy;
            nxt_we    = 1'b0;
            nxt_op    = op;
            nxt_val   = value;
            nxt_cap   = cfg_data;
            if (!nxt_start && pending_words.size() > 0)
            begin
                if (pending_words[0].is_cfg)
                begin
                    // only when nothing is in flight
                    if (expected_q.size() == 0 && !done && !busy && !(start && !busy))
                    begin
                        nxt_we  = 1'b1;
                        nxt_cap = pending_words[0].cap;
                        void'(pending_words.pop_front());
                    end
                end
                else if ($urandom_range(99) >= pending_words[0].idle_pct)
                begin
                    nxt_start = 1'b1;
                    nxt_op    = pending_words[0].op;
                    nxt_val   = pending_words[0].val;
                    void'(pending_words.pop_front());
                end
            end
            start    <= nxt_start;
            cfg_we   <= nxt_we;
            op       <= nxt_op;
            value    <= nxt_val;
            cfg_data <= nxt_cap;
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        deque_outcome_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch(n_words, "result with no word outstanding", DW'(ok), '0);
            end
            else
            begin
                e = expected_q.pop_front();
                if (ok !== e.ok)
                    report_mismatch(e.seq, "ok", DW'(ok), DW'(e.ok));
                if (is_empty !== e.is_empty)
                    report_mismatch(e.seq, "is_empty", DW'(is_empty), DW'(e.is_empty));
                if (is_full !== e.is_full)
                    report_mismatch(e.seq, "is_full", DW'(is_full), DW'(e.is_full));
                if (front_value !== e.front)
                    report_mismatch(e.seq, "front_value", front_value, e.front);
                if (rear_value !== e.rear)
                    report_mismatch(e.seq, "rear_value", rear_value, e.rear);
            end
        end
    end

    // watchdog: cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("Timeout after %0d idle cycles, %0d words left", stall_cycles,
                         pending_words.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int total;
        errors       = 0;
        n_words      = 0;
        n_refused    = 0;
        n_full       = 0;
        n_cfg        = 0;
        stall_cycles = 0;
        dq_head      = '0;
        dq_tail      = '0;
        dq_count     = '0;
        dq_cap_reg   = CAP_W'(CDQ_CAP_RESET);
        rst_n        = 1'b0;

        // directed: refusals on empty, both ends, field extremes
        add_word(OP_POP_FRONT, 16'h1111);
        add_word(OP_POP_REAR, 16'h2222);
        add_word(OP_PUSH_FRONT, 16'hFFFF);
        add_word(OP_PUSH_REAR, 16'h0000);
        add_word(OP_PUSH_FRONT, 16'h1234);
        add_word(OP_PUSH_REAR, 16'h8001);
        add_word(OP_POP_FRONT, 16'h0000);
        add_word(OP_POP_REAR, 16'hFFFF);
        add_word(OP_POP_FRONT, 16'h0000);
        add_word(OP_POP_REAR, 16'h0000);
        add_word(OP_POP_FRONT, 16'h0000);
        // capacity 0 behaves as one entry
        add_capacity(0);
        add_word(OP_PUSH_REAR, 16'hA5A5);
        add_word(OP_PUSH_FRONT, 16'h0F0F);
        add_word(OP_PUSH_REAR, 16'hF0F0);
        add_word(OP_POP_FRONT, 16'h0000);
        add_word(OP_POP_REAR, 16'h0000);
        add_word(OP_PUSH_FRONT, 16'h5A5A);
        add_word(OP_POP_REAR, 16'h0000);
        // two entries: full, wrap at both ends
        add_capacity(2);
        add_word(OP_PUSH_FRONT, 16'h7FFF);
        add_word(OP_PUSH_FRONT, 16'h8000);
        add_word(OP_PUSH_REAR, 16'hCAFE);
        add_word(OP_POP_REAR, 16'h0000);
        add_word(OP_PUSH_REAR, 16'h00FF);
        add_word(OP_POP_FRONT, 16'h0000);

        // random phases; one long one fills the full depth
        add_random(3, 45, 50);
        add_random(2047, 1120, 97);
        add_random(1, 40, 50);
        add_random(5, 45, 60);
        add_random(CDQ_DEPTH, 40, 50);
        add_random(16, 45, 70);
        add_random(7, 45, 30);
        add_random(int'($urandom_range(40, 1)), 45, 50);
        add_random(2, 45, 55);
        add_random(CDQ_DEPTH + 1, 30, 50);

        // sender idling: sparse, then heavy, then none
        total = pending_words.size();
        for (int i = 0; i < total; i++)
            pending_words[i].idle_pct = (i < total / 3) ? 7 : (i < 2 * total / 3) ? 78 : 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || start || cfg_we || expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d words over %0d capacity settings: %0d refused, %0d ended full",
                 n_words, n_cfg, n_refused, n_full);
        if (errors == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> circular_deque.f
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque.sv
rtl/cdq_checker.sv
sim/tb.sv
